// ===== rtl/epmf_pkg.sv =====
// constants and types shared by the echo presence majority filter
// no dependencies

package epmf_pkg;

   parameter int WindowDepthDefault = 7;

   parameter int EchoW    = 16;
   parameter int StampW   = 32;
   parameter int FillOutW = 3;
   parameter int CsrAddrW = 3;
   parameter int CsrDataW = 32;

   parameter int ReqDataW = 48;
   parameter int RspDataW = 40;

   parameter logic [EchoW-1:0] RejectLimitUs = 16'd2;

   typedef enum logic [0:0] {
      RegThreshold = 1'b0
   } csr_reg_type;

endpackage

// ===== rtl/epmf_window.sv =====
// window of the last accepted echo readings with the majority vote
// depends on epmf_pkg

module epmf_window #(
   parameter int WindowDepth = epmf_pkg::WindowDepthDefault,
   parameter int FillW       = $clog2(WindowDepth + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [epmf_pkg::EchoW-1:0] push_echo,
   input  logic [epmf_pkg::EchoW-1:0] threshold,
   output logic [FillW-1:0]           fill,
   output logic [FillW-1:0]           fill_next,
   output logic                       vote_next
);

   logic [epmf_pkg::EchoW-1:0] win_ff [WindowDepth];
   logic [epmf_pkg::EchoW-1:0] win_in [WindowDepth];
   logic [FillW-1:0]           fill_ff;
   logic [FillW-1:0]           fill_in;
   logic                       full;
   logic [FillW-1:0]           high_cnt;

   assign full      = (fill_ff == FillW'(WindowDepth));
   assign fill_next = full ? fill_ff : fill_ff + 1'b1;
   assign fill      = fill_ff;

   // shift when full, otherwise append at the fill position
   for (genvar i = 0; i < WindowDepth; i++) begin : g_entry
      if (i == WindowDepth - 1) begin : g_last
         always_comb begin
            if (full || fill_ff == FillW'(i)) begin
               win_in[i] = push_echo;
            end else begin
               win_in[i] = win_ff[i];
            end
         end
      end else begin : g_mid
         always_comb begin
            if (full) begin
               win_in[i] = win_ff[i+1];
            end else if (fill_ff == FillW'(i)) begin
               win_in[i] = push_echo;
            end else begin
               win_in[i] = win_ff[i];
            end
         end
      end
   end

   always_comb begin
      high_cnt = '0;
      for (int i = 0; i < WindowDepth; i++) begin
         if (FillW'(i) < fill_next && win_in[i] > threshold) begin
            high_cnt = high_cnt + 1'b1;
         end
      end
   end

   assign vote_next = ({high_cnt, 1'b0} > {1'b0, fill_next});
   assign fill_in   = push ? fill_next : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== rtl/echo_presence_majority_filter.sv =====
// echo presence majority filter, top level
// path: req is captured in the input register, then the result register drives rsp_tvalid
// throughput: one transaction per cycle unless rsp stalls; single-pass window update and vote
// reset: synchronous active high; clears threshold, window fill, detection and stamp
// depends on epmf_pkg and epmf_window

module echo_presence_majority_filter #(
   parameter int WindowDepth = epmf_pkg::WindowDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // echo_us [15:0], now_ms [47:16]
   input  logic [epmf_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // detected [0], rejected [1], fill_count [4:2], last_change_ms [36:5], zero [39:37]
   output logic [epmf_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [epmf_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [epmf_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [epmf_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int FillW = $clog2(WindowDepth + 1);

   logic [epmf_pkg::EchoW-1:0]  thresh_ff, thresh_in;
   logic                        in_valid_ff, in_valid_in;
   logic [epmf_pkg::EchoW-1:0]  in_echo_ff, in_echo_in;
   logic [epmf_pkg::StampW-1:0] in_now_ff, in_now_in;
   logic                        detect_ff, detect_in;
   logic [epmf_pkg::StampW-1:0] stamp_ff, stamp_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_detected_ff, out_detected_in;
   logic                        out_rejected_ff, out_rejected_in;
   logic [epmf_pkg::FillOutW-1:0] out_fill_ff, out_fill_in;
   logic [epmf_pkg::StampW-1:0] out_stamp_ff, out_stamp_in;

   logic             stage_go;
   logic             rejected;
   logic             push;
   logic             csr_wr;
   logic             sel_thresh;
   logic [FillW-1:0] fill;
   logic [FillW-1:0] fill_next;
   logic [FillW-1:0] sel_fill;
   logic [FillW+2:0] fill_ext;
   logic             vote_next;

   // config port
   assign csr_pready = 1'b1;
   assign sel_thresh = (csr_paddr[2:2] == epmf_pkg::RegThreshold);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign thresh_in  = (csr_wr && sel_thresh) ? csr_pwdata[epmf_pkg::EchoW-1:0] : thresh_ff;
   assign csr_prdata = sel_thresh
                       ? {{(epmf_pkg::CsrDataW - epmf_pkg::EchoW){1'b0}}, thresh_ff}
                       : '0;

   // handshake
   assign stage_go   = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | stage_go;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_echo_in  = in_echo_ff;
      in_now_in   = in_now_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_echo_in  = req_tdata[epmf_pkg::EchoW-1:0];
         in_now_in   = req_tdata[epmf_pkg::EchoW +: epmf_pkg::StampW];
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end
   end

   assign rejected = (in_echo_ff <= epmf_pkg::RejectLimitUs);
   assign push     = stage_go & ~rejected;

   epmf_window #(
      .WindowDepth (WindowDepth),
      .FillW       (FillW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_echo (in_echo_ff),
      .threshold (thresh_ff),
      .fill      (fill),
      .fill_next (fill_next),
      .vote_next (vote_next)
   );

   assign sel_fill = rejected ? fill : fill_next;
   assign fill_ext = {3'b000, sel_fill};

   always_comb begin
      detect_in = detect_ff;
      stamp_in  = stamp_ff;
      if (push) begin
         detect_in = vote_next;
         if (vote_next != detect_ff) begin
            stamp_in = in_now_ff;
         end
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_detected_in = out_detected_ff;
      out_rejected_in = out_rejected_ff;
      out_fill_in     = out_fill_ff;
      out_stamp_in    = out_stamp_ff;
      if (stage_go) begin
         out_valid_in    = 1'b1;
         out_detected_in = detect_in;
         out_rejected_in = rejected;
         out_fill_in     = fill_ext[epmf_pkg::FillOutW-1:0];
         out_stamp_in    = stamp_in;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_stamp_ff, out_fill_ff, out_rejected_ff, out_detected_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= '0;
         in_valid_ff  <= 1'b0;
         detect_ff    <= 1'b0;
         stamp_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         in_valid_ff  <= in_valid_in;
         detect_ff    <= detect_in;
         stamp_ff     <= stamp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_echo_ff      <= in_echo_in;
      in_now_ff       <= in_now_in;
      out_detected_ff <= out_detected_in;
      out_rejected_ff <= out_rejected_in;
      out_fill_ff     <= out_fill_in;
      out_stamp_ff    <= out_stamp_in;
   end

   // window never holds more than its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= FillW'(WindowDepth))
      else $error("window fill above depth");

   // fill only grows between resets
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill >= $past(fill))
      else $error("window fill decreased");

   // a change of detection records the timestamp of that transaction
   a_stamp_on_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && detect_ff != $past(detect_ff)) |-> stamp_ff == $past(in_now_ff))
      else $error("detection changed without timestamp update");

   // a rejected reading leaves the window untouched
   a_reject_no_push: assert property (@(posedge clock) disable iff (reset)
      (stage_go && rejected) |=> fill == $past(fill))
      else $error("rejected reading changed the window");

endmodule

// ===== sim/echo_presence_majority_filter_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the echo presence majority filter: directed
// runs and threshold sweeps with random readings, predicted by a window model
// depends on epmf_pkg and the echo_presence_majority_filter rtl

module echo_presence_majority_filter_tb;

   localparam int Depth      = epmf_pkg::WindowDepthDefault;
   localparam int StallLimit = 1000;
   localparam int EchoW      = epmf_pkg::EchoW;
   localparam int StampW     = epmf_pkg::StampW;
   localparam int ReqDataW   = epmf_pkg::ReqDataW;
   localparam int RspDataW   = epmf_pkg::RspDataW;
   localparam int CsrAddrW   = epmf_pkg::CsrAddrW;
   localparam int CsrDataW   = epmf_pkg::CsrDataW;

   // last field in the low bits, matching rsp_tdata[36:0]
   typedef struct packed {
      logic [StampW-1:0] last_change_ms;
      logic [2:0]        fill_count;
      logic              rejected;
      logic              detected;
   } vote_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic [ReqDataW-1:0] req_tdata   = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr   = '0;
   logic [CsrDataW-1:0] csr_pwdata  = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   // pending readings and predicted votes
   logic [ReqDataW-1:0] readings[$];
   vote_type            expected_votes[$];

   // window model state
   logic [EchoW-1:0]  held_echo[Depth];
   int unsigned       held_count;
   logic              presence;
   logic [StampW-1:0] change_ms;
   logic [EchoW-1:0]  cut_us;

   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned recv_hold = 0;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;

   echo_presence_majority_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic advance_window(input logic [EchoW-1:0] echo, input logic [StampW-1:0] now);
      vote_type    v;
      int unsigned highs;
      logic        next;
      v.rejected = (echo <= epmf_pkg::RejectLimitUs);
      if (!v.rejected) begin
         if (held_count == Depth) begin
            for (int i = 0; i < Depth - 1; i++) held_echo[i] = held_echo[i + 1];
            held_echo[Depth - 1] = echo;
         end else begin
            held_echo[held_count] = echo;
            held_count++;
         end
         highs = 0;
         for (int i = 0; i < held_count; i++) if (held_echo[i] > cut_us) highs++;
         next = (2 * highs > held_count);
         if (next != presence) change_ms = now;
         presence = next;
      end
      v.detected       = presence;
      v.fill_count     = held_count[2:0];
      v.last_change_ms = change_ms;
      expected_votes.insert(expected_votes.size(), v);
   endtask

   task automatic queue_reading(input logic [EchoW-1:0] echo, input logic [StampW-1:0] now);
      readings.insert(readings.size(), {now, echo});
   endtask

   task automatic wait_drained();
      while (readings.size() > 0 || req_tvalid || expected_votes.size() > 0) @(negedge clock);
   endtask

   task automatic csr_write(input epmf_pkg::csr_reg_type idx, input logic [CsrDataW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         epmf_pkg::RegThreshold: cut_us = value[EchoW-1:0];
         default: ;
      endcase
   endtask

   // reading source
   always @(posedge clock) begin
      logic keep;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         keep = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) advance_window(req_tdata[15:0], req_tdata[47:16]);
         if (!keep) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (readings.size() > 0) begin
               req_tdata <= readings[0];
               readings.delete(0);
               keep = 1'b1;
               if ($urandom_range(31) == 0) send_calm = !send_calm;
               send_gap = send_calm ? 0 : $urandom_range(8);
            end
         end
         req_tvalid <= keep;
      end
   end

   // vote checker
   always @(posedge clock) begin
      vote_type want;
      vote_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[36:0];
            if (expected_votes.size() == 0) begin
               flag_mismatch("vote transaction with no reading pending");
            end else begin
               want = expected_votes[0];
               expected_votes.delete(0);
               if (got.detected !== want.detected)
                  flag_mismatch($sformatf("detected %b, want %b", got.detected, want.detected));
               if (got.rejected !== want.rejected)
                  flag_mismatch($sformatf("rejected %b, want %b", got.rejected, want.rejected));
               if (got.fill_count !== want.fill_count)
                  flag_mismatch($sformatf("fill_count %0d, want %0d",
                                          got.fill_count, want.fill_count));
               if (got.last_change_ms !== want.last_change_ms)
                  flag_mismatch($sformatf("last_change_ms %h, want %h",
                                          got.last_change_ms, want.last_change_ms));
            end
            if ($urandom_range(31) == 0) recv_calm = !recv_calm;
            recv_hold = recv_calm ? 0 : $urandom_range(8);
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on stalled handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_psel && csr_penable && csr_pready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= StallLimit) begin
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned       sweep[12];
      int unsigned       thr;
      int unsigned       pick;
      int unsigned       run_left;
      bit                lean;
      logic [EchoW-1:0]  echo;
      logic [StampW-1:0] now;

      sweep = '{65535, 0, 3, 2, 580, 1200, 40000, 65534, 1, 17, 9000, 0};
      sweep[11] = $urandom_range(65535);
      for (int i = 0; i < Depth; i++) held_echo[i] = '0;
      held_count = 0;
      presence   = 1'b0;
      change_ms  = '0;
      cut_us     = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // threshold at reset value: rejects, first detection, extremes
      queue_reading(16'd0, 32'd0);
      queue_reading(16'd1, 32'd1);
      queue_reading(16'd2, 32'd2);
      queue_reading(16'd3, 32'hFFFF_FFFF);
      queue_reading(16'hFFFF, 32'd100);
      wait_drained();

      // ties, threshold equality, window wrap
      csr_write(epmf_pkg::RegThreshold, 32'd1000);
      queue_reading(16'd500, 32'd200);
      queue_reading(16'd2000, 32'd300);
      queue_reading(16'd2, 32'd301);
      queue_reading(16'd2000, 32'd400);
      queue_reading(16'd1000, 32'd500);
      queue_reading(16'd1001, 32'd600);
      queue_reading(16'd1000, 32'd700);
      queue_reading(16'd0, 32'd800);
      queue_reading(16'hFFFF, 32'h8000_0000);
      queue_reading(16'd999, 32'h7FFF_FFFF);
      queue_reading(16'd999, 32'h1234_5678);
      queue_reading(16'd3, 32'd900);
      queue_reading(16'd1, 32'd901);
      queue_reading(16'd4, 32'd902);
      queue_reading(16'd5, 32'd903);
      queue_reading(16'hAAAA, 32'h5555_5555);
      queue_reading(16'h5555, 32'hAAAA_AAAA);
      wait_drained();

      now = '0;
      for (int p = 0; p < 12; p++) begin
         thr = sweep[p];
         csr_write(epmf_pkg::RegThreshold, thr);
         run_left = 0;
         lean = 1'b0;
         for (int n = 0; n < 160; n++) begin
            if (run_left == 0) begin
               lean = ($urandom_range(1) == 1);
               run_left = $urandom_range(12, 2);
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 8)
               echo = EchoW'($urandom_range(2));
            else if (pick < 18)
               echo = EchoW'($urandom);
            else if (pick < 24)
               echo = EchoW'(thr);
            else if (lean)
               echo = (thr > 65535 - 401) ? 16'hFFFF : EchoW'(thr + 1 + $urandom_range(400));
            else
               echo = (thr < 400) ? EchoW'($urandom_range(thr))
                                  : EchoW'(thr - $urandom_range(400));
            if ($urandom_range(49) == 0) now = $urandom;
            else now = now + $urandom_range(120);
            queue_reading(echo, now);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/epmf_pkg.sv
rtl/epmf_window.sv
rtl/echo_presence_majority_filter.sv
sim/echo_presence_majority_filter_tb.sv
